/* src/circular_deque_defines.svh */
// ----------------------------------------------------------------------------
// Circular deque assertion macros
// Shared macros for the concurrent checks on the deque's ports.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/cd_pkg.sv */
// ----------------------------------------------------------------------------
// Circular deque package
// Request and status codes, controller states and the command and status
// groups exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package cd_pkg;

  localparam int WORD_W = 32;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;

  // Value reported where there is no element to show.
  localparam logic signed [WORD_W-1:0] NEG_ONE = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_REAR  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_type_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RDWAIT,
    S_EMIT
  } cd_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;
    logic rd_capture;
    logic out_load;
  } cd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_read;
  } cd_sts_t;

endpackage

/* src/cd_if.sv */
// ----------------------------------------------------------------------------
// Circular deque channel interfaces
// Request channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cd_in_if;
  logic                              valid;
  logic                              ready;
  logic [cd_pkg::REQ_W-1:0]          req_type;
  logic signed [cd_pkg::WORD_W-1:0]  push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface cd_out_if;
  logic                              valid;
  logic                              ready;
  logic [cd_pkg::STAT_W-1:0]         status;
  logic signed [cd_pkg::WORD_W-1:0]  popped_value;
  logic signed [cd_pkg::WORD_W-1:0]  front_value;
  logic signed [cd_pkg::WORD_W-1:0]  rear_value;
  logic                              is_empty;
  logic                              is_full;

  modport source (output valid, output status, output popped_value, output front_value,
                  output rear_value, output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input popped_value, input front_value,
                  input rear_value, input is_empty, input is_full, output ready);
endinterface

/* src/cd_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/cd_ctrl.sv */
// ----------------------------------------------------------------------------
// Circular deque controller
// Sequences each request: execute, wait for a store read where a pop needs one, then emit.
// ----------------------------------------------------------------------------
module cd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  cd_pkg::cd_sts_t sts,
  output cd_pkg::cd_cmd_t cmd
);

  cd_pkg::cd_state_t state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_free;

  // The result register can take a new result when empty or being drained.
  assign slot_free = !out_valid_r || out_ready;

  // State and result-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cd_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cd_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.need_read ? cd_pkg::S_RDWAIT : cd_pkg::S_EMIT;
        end
      end
      cd_pkg::S_RDWAIT: begin
        state_nxt = cd_pkg::S_EMIT;
      end
      cd_pkg::S_EMIT: begin
        if (slot_free) begin
          state_nxt = cd_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cd_pkg::S_IDLE;
      end
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      cd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.exec = in_valid;
      end
      cd_pkg::S_RDWAIT: begin
        cmd.rd_capture = 1'b1;
      end
      cd_pkg::S_EMIT: begin
        cmd.out_load = slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // A loaded result stays valid until its transfer.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* src/cd_datapath.sv */
// ----------------------------------------------------------------------------
// Circular deque datapath
// Ring pointers, cached end values, the ring store and the result register.
// ----------------------------------------------------------------------------
module cd_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cd_pkg::cd_cmd_t                   cmd,
  output cd_pkg::cd_sts_t                   sts,
  input  logic [cd_pkg::REQ_W-1:0]          in_req_type,
  input  logic signed [cd_pkg::WORD_W-1:0]  in_push_value,
  output logic [cd_pkg::STAT_W-1:0]         out_status,
  output logic signed [cd_pkg::WORD_W-1:0]  out_popped_value,
  output logic signed [cd_pkg::WORD_W-1:0]  out_front_value,
  output logic signed [cd_pkg::WORD_W-1:0]  out_rear_value,
  output logic                              out_is_empty,
  output logic                              out_is_full
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0]                    front_idx_r, front_idx_nxt;
  logic [AW-1:0]                    rear_idx_r, rear_idx_nxt;
  logic                             empty_r, empty_nxt;
  logic                             pop_front_r, pop_front_nxt;
  logic signed [cd_pkg::WORD_W-1:0] front_val_r, front_val_nxt;
  logic signed [cd_pkg::WORD_W-1:0] rear_val_r, rear_val_nxt;
  logic [cd_pkg::STAT_W-1:0]        status_r, status_nxt;
  logic signed [cd_pkg::WORD_W-1:0] popped_r, popped_nxt;

  logic [cd_pkg::STAT_W-1:0]        res_status_r;
  logic signed [cd_pkg::WORD_W-1:0] res_popped_r, res_front_r, res_rear_r;
  logic                             res_empty_r, res_full_r;

  logic                             ram_we, ram_re;
  logic [AW-1:0]                    ram_waddr, ram_raddr;
  logic [cd_pkg::WORD_W-1:0]        ram_rdata;
  logic                             full_now;

  function automatic logic [AW-1:0] idx_up(input logic [AW-1:0] i);
    return (i == LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] idx_down(input logic [AW-1:0] i);
    return (i == '0) ? LAST : i - 1'b1;
  endfunction

  // Full when occupied and the rear sits just behind the front.
  assign full_now = !empty_r && (rear_idx_r == idx_down(front_idx_r));

  // A pop that leaves elements behind must fetch the new end value.
  assign sts.need_read = (in_req_type inside {cd_pkg::REQ_POP_FRONT, cd_pkg::REQ_POP_REAR})
                         && !empty_r && (front_idx_r != rear_idx_r);

  // Request execution and read-data capture.
  always_comb begin
    front_idx_nxt = front_idx_r;
    rear_idx_nxt  = rear_idx_r;
    empty_nxt     = empty_r;
    pop_front_nxt = pop_front_r;
    front_val_nxt = front_val_r;
    rear_val_nxt  = rear_val_r;
    status_nxt    = status_r;
    popped_nxt    = popped_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    if (cmd.exec) begin
      popped_nxt = cd_pkg::NEG_ONE;
      status_nxt = cd_pkg::ST_DONE;
      case (in_req_type)
        cd_pkg::REQ_PUSH_FRONT, cd_pkg::REQ_PUSH_REAR: begin
          if (full_now) begin
            status_nxt = cd_pkg::ST_FULL;
          end else if (empty_r) begin
            // First element goes to slot zero and is both ends.
            front_idx_nxt = '0;
            rear_idx_nxt  = '0;
            empty_nxt     = 1'b0;
            ram_we        = 1'b1;
            ram_waddr     = '0;
            front_val_nxt = in_push_value;
            rear_val_nxt  = in_push_value;
          end else if (in_req_type == cd_pkg::REQ_PUSH_FRONT) begin
            front_idx_nxt = idx_down(front_idx_r);
            ram_we        = 1'b1;
            ram_waddr     = idx_down(front_idx_r);
            front_val_nxt = in_push_value;
          end else begin
            rear_idx_nxt  = idx_up(rear_idx_r);
            ram_we        = 1'b1;
            ram_waddr     = idx_up(rear_idx_r);
            rear_val_nxt  = in_push_value;
          end
        end
        cd_pkg::REQ_POP_FRONT, cd_pkg::REQ_POP_REAR: begin
          if (empty_r) begin
            status_nxt = cd_pkg::ST_EMPTY;
          end else begin
            popped_nxt = (in_req_type == cd_pkg::REQ_POP_FRONT) ? front_val_r : rear_val_r;
            if (front_idx_r == rear_idx_r) begin
              // Last element removed: the ring returns to its start.
              front_idx_nxt = '0;
              rear_idx_nxt  = '0;
              empty_nxt     = 1'b1;
            end else if (in_req_type == cd_pkg::REQ_POP_FRONT) begin
              front_idx_nxt = idx_up(front_idx_r);
              ram_re        = 1'b1;
              ram_raddr     = idx_up(front_idx_r);
              pop_front_nxt = 1'b1;
            end else begin
              rear_idx_nxt  = idx_down(rear_idx_r);
              ram_re        = 1'b1;
              ram_raddr     = idx_down(rear_idx_r);
              pop_front_nxt = 1'b0;
            end
          end
        end
        default: begin
          status_nxt = cd_pkg::ST_DONE;
        end
      endcase
    end

    if (cmd.rd_capture) begin
      if (pop_front_r) begin
        front_val_nxt = ram_rdata;
      end else begin
        rear_val_nxt = ram_rdata;
      end
    end
  end

  // Pointer and occupancy registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_idx_r <= '0;
      rear_idx_r  <= '0;
      empty_r     <= 1'b1;
      pop_front_r <= 1'b0;
    end else begin
      front_idx_r <= front_idx_nxt;
      rear_idx_r  <= rear_idx_nxt;
      empty_r     <= empty_nxt;
      pop_front_r <= pop_front_nxt;
    end
  end

  // Cached end values and per-request results.
  always_ff @(posedge clk) begin
    front_val_r <= front_val_nxt;
    rear_val_r  <= rear_val_nxt;
    status_r    <= status_nxt;
    popped_r    <= popped_nxt;
  end

  // Result register, loaded when the controller emits.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_status_r <= status_r;
      res_popped_r <= popped_r;
      res_front_r  <= empty_r ? cd_pkg::NEG_ONE : front_val_r;
      res_rear_r   <= empty_r ? cd_pkg::NEG_ONE : rear_val_r;
      res_empty_r  <= empty_r;
      res_full_r   <= full_now;
    end
  end

  assign out_status       = res_status_r;
  assign out_popped_value = res_popped_r;
  assign out_front_value  = res_front_r;
  assign out_rear_value   = res_rear_r;
  assign out_is_empty     = res_empty_r;
  assign out_is_full      = res_full_r;

  // Ring store.
  cd_ram #(
    .WIDTH (cd_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_push_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* src/circular_deque.sv */
// ----------------------------------------------------------------------------
// Circular deque
// Double-ended queue of signed 32-bit words held in a ring store.
// ----------------------------------------------------------------------------
//   Channel   Direction  Payload
//   in_chan   sink       req_type, push_value
//   out_chan  source     status, popped_value, front_value, rear_value,
//                        is_empty, is_full
//
// A push, a refused request or a last-element pop goes from S_IDLE to S_EMIT;
// other pops pass S_RDWAIT on the way, as the new end value comes from the
// store's registered read port. S_EMIT loads the result register, whose valid
// is registered; a new request is taken only back in S_IDLE.
// Reset leaves the deque empty with both pointers at slot zero.
// A stalled result is held in the result register while the next request is
// taken and executed; it is emitted once the held result has transferred.
// ----------------------------------------------------------------------------
module circular_deque #(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  cd_in_if.sink    in_chan,
  cd_out_if.source out_chan
);

  cd_pkg::cd_cmd_t cmd;
  cd_pkg::cd_sts_t sts;

  // Sequencing of each request.
  cd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Deque state, store and result register.
  cd_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_req_type      (in_chan.req_type),
    .in_push_value    (in_chan.push_value),
    .out_status       (out_chan.status),
    .out_popped_value (out_chan.popped_value),
    .out_front_value  (out_chan.front_value),
    .out_rear_value   (out_chan.rear_value),
    .out_is_empty     (out_chan.is_empty),
    .out_is_full      (out_chan.is_full)
  );

endmodule

/* src/cd_checker.sv */
// ----------------------------------------------------------------------------
// Circular deque checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "circular_deque_defines.svh"

module cd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [cd_pkg::STAT_W-1:0]         out_status,
  input logic signed [cd_pkg::WORD_W-1:0]  out_popped_value,
  input logic signed [cd_pkg::WORD_W-1:0]  out_front_value,
  input logic signed [cd_pkg::WORD_W-1:0]  out_rear_value,
  input logic                              out_is_empty,
  input logic                              out_is_full
);

  // A result offered must stay offered until its transfer.
  `CD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result withdrawn")

  // An empty deque shows no end values and cannot be full.
  `CD_ASSERT_NOW(a_empty_view, out_valid && out_is_empty, out_front_value == cd_pkg::NEG_ONE && out_rear_value == cd_pkg::NEG_ONE && !out_is_full, "empty result inconsistent")

  // A refused push is only reported against a full deque.
  `CD_ASSERT_NOW(a_full_refusal, out_valid && out_status == cd_pkg::ST_FULL, out_is_full && out_popped_value == cd_pkg::NEG_ONE, "push refused while not full")

  // A refused pop is only reported against an empty deque.
  `CD_ASSERT_NOW(a_empty_refusal, out_valid && out_status == cd_pkg::ST_EMPTY, out_is_empty && out_popped_value == cd_pkg::NEG_ONE, "pop refused while not empty")

endmodule

bind circular_deque cd_checker u_cd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_status       (out_chan.status),
  .out_popped_value (out_chan.popped_value),
  .out_front_value  (out_chan.front_value),
  .out_rear_value   (out_chan.rear_value),
  .out_is_empty     (out_chan.is_empty),
  .out_is_full      (out_chan.is_full)
);

/* tb/tb_circular_deque.sv */
// ----------------------------------------------------------------------------
// Circular deque testbench
// Drives push and pop requests into the deque and predicts every result from a
// shadow copy of the ring, its two pointers and the empty flag. Each result
// transfer is checked field by field against the oldest prediction. Traffic
// runs with random gaps on both channels, a long stall of the result channel
// that backs the deque up, and pauses that let all results drain.
// ----------------------------------------------------------------------------
module tb_circular_deque;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 16;
  localparam int STALL_LIMIT = 5000;
  localparam int MAX_SHOWN   = 10;
  localparam int SETTLE      = 8;
  localparam int HOLD_CYCLES = 80;

  typedef logic signed [cd_pkg::WORD_W-1:0] word_t;

  // One expected result as the deque should report it.
  typedef struct {
    cd_pkg::status_t status;
    word_t           popped;
    word_t           front;
    word_t           rear;
    logic            empty;
    logic            full;
  } deque_result_t;

  logic clk = 1'b0;
  logic rst_n;

  cd_in_if  in_chan ();
  cd_out_if out_chan ();

  circular_deque #(
    .DEPTH (DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #10 clk = ~clk;

  // Shadow state of the deque.
  word_t shadow_ring [DEPTH];
  int    head_slot;
  int    tail_slot;
  bit    shadow_empty;

  deque_result_t pending_results [$];
  int error_count        = 0;
  int sender_gap_pct     = 0;
  int receiver_stall_pct = 0;
  int hold_off_req       = 0;
  int hold_off_done      = 0;
  int hold_left          = 0;
  int quiet_cycles       = 0;

  function automatic int ring_prev(int slot);
    return (slot == 0) ? DEPTH - 1 : slot - 1;
  endfunction

  function automatic int ring_next(int slot);
    return (slot == DEPTH - 1) ? 0 : slot + 1;
  endfunction

  function automatic bit shadow_full();
    return !shadow_empty && tail_slot == ring_prev(head_slot);
  endfunction

  // Applies one request to the shadow deque and returns the expected result.
  function automatic deque_result_t apply_request(cd_pkg::req_type_t req, word_t value);
    deque_result_t res;
    res.status = cd_pkg::ST_DONE;
    res.popped = cd_pkg::NEG_ONE;
    if (req == cd_pkg::REQ_PUSH_FRONT || req == cd_pkg::REQ_PUSH_REAR) begin
      if (shadow_full()) begin
        res.status = cd_pkg::ST_FULL;
      end else if (shadow_empty) begin
        head_slot      = 0;
        tail_slot      = 0;
        shadow_empty   = 1'b0;
        shadow_ring[0] = value;
      end else if (req == cd_pkg::REQ_PUSH_FRONT) begin
        head_slot              = ring_prev(head_slot);
        shadow_ring[head_slot] = value;
      end else begin
        tail_slot              = ring_next(tail_slot);
        shadow_ring[tail_slot] = value;
      end
    end else if (shadow_empty) begin
      res.status = cd_pkg::ST_EMPTY;
    end else begin
      res.popped = (req == cd_pkg::REQ_POP_FRONT) ? shadow_ring[head_slot]
                                                  : shadow_ring[tail_slot];
      // Taking the last element empties the deque and rewinds both pointers.
      if (head_slot == tail_slot) begin
        head_slot    = 0;
        tail_slot    = 0;
        shadow_empty = 1'b1;
      end else if (req == cd_pkg::REQ_POP_FRONT) begin
        head_slot = ring_next(head_slot);
      end else begin
        tail_slot = ring_prev(tail_slot);
      end
    end
    res.front = shadow_empty ? cd_pkg::NEG_ONE : shadow_ring[head_slot];
    res.rear  = shadow_empty ? cd_pkg::NEG_ONE : shadow_ring[tail_slot];
    res.empty = shadow_empty;
    res.full  = shadow_full();
    return res;
  endfunction

  function automatic void compare_field(string field, logic [cd_pkg::WORD_W-1:0] want,
                                        logic [cd_pkg::WORD_W-1:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= MAX_SHOWN)
        $display("mismatch on %s: expected %0d (0x%08h), got %0d (0x%08h)",
                 field, $signed(want), want, $signed(got), got);
    end
  endfunction

  // Offers one request after a random gap and returns at the edge of its transfer.
  task automatic send_request(cd_pkg::req_type_t req, word_t value);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < sender_gap_pct) gap++;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.req_type   <= req;
    in_chan.push_value <= value;
    forever begin
      @(negedge clk);
      if (in_chan.ready) break;
      @(posedge clk);
    end
    pending_results.push_back(apply_request(req, value));
    @(posedge clk);
  endtask

  // Holds the request channel quiet until every predicted result has arrived.
  task automatic wait_results_drained();
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(int push_pct);
    cd_pkg::req_type_t req;
    word_t             value;
    bit                at_front;
    at_front = 1'($urandom_range(1));
    if ($urandom_range(99) < push_pct)
      req = at_front ? cd_pkg::REQ_PUSH_FRONT : cd_pkg::REQ_PUSH_REAR;
    else
      req = at_front ? cd_pkg::REQ_POP_FRONT : cd_pkg::REQ_POP_REAR;
    case ($urandom_range(15))
      0:       value = 32'sh7fff_ffff;
      1:       value = 32'sh8000_0000;
      2:       value = '0;
      3:       value = cd_pkg::NEG_ONE;
      default: value = $urandom;
    endcase
    send_request(req, value);
  endtask

  // Bursts that lean towards pushing, popping or neither, so that the deque
  // swings between empty and full and the pointers wrap many times.
  task automatic run_bursts(int n_items);
    int sent;
    int burst;
    int push_pct;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(4, 40);
      case ($urandom_range(2))
        0:       push_pct = 15;
        1:       push_pct = 50;
        default: push_pct = 85;
      endcase
      repeat (burst) begin
        send_random(push_pct);
        sent++;
      end
    end
  endtask

  // Pops from the empty deque, extreme values in and out, last-element pop.
  task automatic test_empty_pops();
    send_request(cd_pkg::REQ_POP_FRONT, 32'sh7fff_ffff);
    send_request(cd_pkg::REQ_POP_REAR, '0);
    send_request(cd_pkg::REQ_PUSH_FRONT, 32'sh7fff_ffff);
    send_request(cd_pkg::REQ_PUSH_REAR, 32'sh8000_0000);
    send_request(cd_pkg::REQ_POP_FRONT, cd_pkg::NEG_ONE);
    send_request(cd_pkg::REQ_POP_REAR, '0);
  endtask

  // Fills the deque from both ends so the front wraps, then pushes into it full.
  task automatic test_fill_and_refuse();
    for (int i = 0; i < DEPTH; i++)
      send_request((i % 2) ? cd_pkg::REQ_PUSH_FRONT : cd_pkg::REQ_PUSH_REAR, $urandom);
    send_request(cd_pkg::REQ_PUSH_FRONT, 32'sh8000_0000);
    send_request(cd_pkg::REQ_PUSH_REAR, 32'sh7fff_ffff);
    send_request(cd_pkg::REQ_POP_FRONT, '0);
  endtask

  task automatic test_random_traffic(int n_items, int gap_pct, int stall_pct);
    sender_gap_pct     = gap_pct;
    receiver_stall_pct = stall_pct;
    run_bursts(n_items);
  endtask

  // The result channel stalls for a long stretch while requests keep coming.
  task automatic test_backpressure();
    sender_gap_pct     = 0;
    receiver_stall_pct = 0;
    hold_off_req++;
    repeat (30) send_random(85);
  endtask

  // Result channel readiness, with an occasional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_chan.ready <= 1'b0;
      hold_left--;
    end else if (hold_off_done != hold_off_req) begin
      out_chan.ready <= 1'b0;
      hold_left     = HOLD_CYCLES - 1;
      hold_off_done = hold_off_req;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Result checking, sampled half a cycle away from the driving edge.
  always @(negedge clk) begin
    deque_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_SHOWN)
          $display("unexpected result: status %0d popped %0d", out_chan.status,
                   out_chan.popped_value);
      end else begin
        want = pending_results.pop_front();
        compare_field("status", word_t'(want.status), word_t'(out_chan.status));
        compare_field("popped_value", want.popped, out_chan.popped_value);
        compare_field("front_value", want.front, out_chan.front_value);
        compare_field("rear_value", want.rear, out_chan.rear_value);
        compare_field("is_empty", word_t'(want.empty), word_t'(out_chan.is_empty));
        compare_field("is_full", word_t'(want.full), word_t'(out_chan.is_full));
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(negedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_circular_deque: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.req_type   <= cd_pkg::REQ_PUSH_FRONT;
    in_chan.push_value <= '0;
    head_slot    = 0;
    tail_slot    = 0;
    shadow_empty = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_pops();
    test_fill_and_refuse();
    wait_results_drained();
    test_random_traffic(370, 14, 62);
    wait_results_drained();
    test_random_traffic(370, 62, 14);
    wait_results_drained();
    test_backpressure();
    wait_results_drained();
    test_random_traffic(370, 0, 0);
    wait_results_drained();
    repeat (SETTLE) @(posedge clk);

    if (error_count == 0)
      $display("tb_circular_deque: done, clean");
    else
      $display("tb_circular_deque: done, errors");
    $finish;
  end

endmodule
